[rtl/core/mrd_pkg.sv]
// Package for the MQTT receive deframer: event codes, opcodes, packet
// types, parser phase encoding and the result struct. No dependencies.
`timescale 1ns / 1ps

package mrd_pkg;

    localparam int ACC_W = 28;  // remaining length and body position
    localparam int CNT_W = 3;   // length byte counter
    localparam int TOP_W = 16;  // topic length
    localparam int MS_W  = 17;  // message start offset, at most 2 + 65535 + 2

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [3:0] PKT_CONNACK = 4'd2;
    localparam logic [3:0] PKT_PUBLISH = 4'd3;

    localparam logic [2:0] EV_MSG_BYTE     = 3'd0;
    localparam logic [2:0] EV_EMPTY_MSG    = 3'd1;
    localparam logic [2:0] EV_CONNACK_OK   = 3'd2;
    localparam logic [2:0] EV_CONNACK_REF  = 3'd3;
    localparam logic [2:0] EV_BAD_LENGTH   = 3'd4;
    localparam logic [2:0] EV_BAD_TOPIC    = 3'd5;
    localparam logic [2:0] EV_SHORT_PUB    = 3'd6;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_OVERRUN = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] event_res;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

[rtl/core/mrd_in_if.sv]
// Input channel of the MQTT receive deframer: opcode and received byte.
// Uses no package.
`timescale 1ns / 1ps

interface mrd_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

[rtl/core/mrd_out_if.sv]
// Result channel of the MQTT receive deframer: event, data byte and last flag.
// Uses no package.
`timescale 1ns / 1ps

interface mrd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output event_res, output data, output last,
                    input ready);
    modport sink   (input valid, input event_res, input data, input last,
                    output ready);
endinterface

[rtl/core/mrd_parser.sv]
// Parser state and next-state logic for the MQTT receive deframer.
// Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_parser
    import mrd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    output res_t       res
);

    phase_t             phase_reg,  phase_next;
    logic [7:0]         header_reg, header_next;
    logic [ACC_W-1:0]   accum_reg,  accum_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [ACC_W-1:0]   pos_reg,    pos_next;
    logic [TOP_W-1:0]   topic_reg,  topic_next;
    logic [MS_W-1:0]    mstart_reg, mstart_next;
    logic [7:0]         ack_reg,    ack_next;

    // Report given when a packet ends without streaming a byte on this word.
    function automatic res_t end_report(logic [3:0] ptype, logic [ACC_W-1:0] rem,
                                        logic [7:0] ack, logic [TOP_W-1:0] tl,
                                        logic [MS_W-1:0] ms);
        res_t r;
        r = '0;
        if (ptype == PKT_CONNACK)
        begin
            r.valid     = 1'b1;
            r.event_res = (rem >= ACC_W'(2) && ack == 8'h00) ? EV_CONNACK_OK
                                                               : EV_CONNACK_REF;
        end
        else if (ptype == PKT_PUBLISH)
        begin
            if (rem < ACC_W'(2))
            begin
                r.valid     = 1'b1;
                r.event_res = EV_SHORT_PUB;
            end
            else if (ACC_W'(tl) + ACC_W'(2) > rem)
            begin
                r.valid     = 1'b1;
                r.event_res = EV_BAD_TOPIC;
            end
            else if (ACC_W'(ms) == rem)
            begin
                r.valid     = 1'b1;
                r.event_res = EV_EMPTY_MSG;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        logic [ACC_W-1:0] shifted;
        logic [ACC_W-1:0] topic_end;
        logic [MS_W-1:0]  offset;
        logic [3:0]       ptype;

        phase_next  = phase_reg;
        header_next = header_reg;
        accum_next  = accum_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        topic_next  = topic_reg;
        mstart_next = mstart_reg;
        ack_next    = ack_reg;
        res         = '0;
        ptype       = header_reg[7:4];
        topic_end   = '0;
        offset      = '0;

        unique case (count_reg[1:0])
            2'd0:    shifted = ACC_W'(rx_byte[6:0]);
            2'd1:    shifted = ACC_W'(rx_byte[6:0]) << 7;
            2'd2:    shifted = ACC_W'(rx_byte[6:0]) << 14;
            default: shifted = ACC_W'(rx_byte[6:0]) << 21;
        endcase

        if (step)
        begin
            if (opcode == OP_CLEAR)
            begin
                phase_next  = PH_HEADER;
                header_next = '0;
                accum_next  = '0;
                count_next  = '0;
                pos_next    = '0;
                topic_next  = '0;
                mstart_next = '0;
                ack_next    = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        phase_next  = PH_LENGTH;
                        header_next = rx_byte;
                        accum_next  = '0;
                        count_next  = '0;
                        pos_next    = '0;
                        topic_next  = '0;
                        mstart_next = '0;
                        ack_next    = '0;
                    end
                    PH_LENGTH:
                    begin
                        accum_next = accum_reg | shifted;
                        count_next = count_reg + CNT_W'(1);
                        if (rx_byte[7])
                        begin
                            if (count_next >= CNT_W'(MAX_LENGTH_BYTES))
                                phase_next = PH_OVERRUN;
                        end
                        else if (accum_next == '0)
                        begin
                            // zero-length packet ends on its last length byte
                            phase_next = PH_HEADER;
                            res = end_report(ptype, accum_next, ack_reg, topic_reg,
                                             mstart_reg);
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    PH_OVERRUN:
                    begin
                        // swallow this word and resync on the next one
                        phase_next    = PH_HEADER;
                        res.valid     = 1'b1;
                        res.event_res = EV_BAD_LENGTH;
                    end
                    PH_BODY:
                    begin
                        if (ptype == PKT_CONNACK)
                        begin
                            if (pos_reg == ACC_W'(1))
                                ack_next = rx_byte;
                        end
                        else if (ptype == PKT_PUBLISH)
                        begin
                            if (pos_reg == '0)
                            begin
                                topic_next = {rx_byte, 8'h00};
                            end
                            else if (pos_reg == ACC_W'(1))
                            begin
                                topic_next = topic_reg | {8'h00, rx_byte};
                                topic_end  = ACC_W'(topic_next) + ACC_W'(2);
                                offset     = MS_W'(topic_end);
                                // skip the packet id when QoS is set and it fits
                                if (topic_end <= accum_reg && header_reg[2:1] != 2'b00
                                    && accum_reg >= topic_end + ACC_W'(2))
                                    offset = offset + MS_W'(2);
                                mstart_next = offset;
                            end
                            else if (pos_reg >= ACC_W'(mstart_reg)
                                     && ACC_W'(topic_reg) + ACC_W'(2) <= accum_reg)
                            begin
                                res.valid     = 1'b1;
                                res.event_res = EV_MSG_BYTE;
                                res.data      = rx_byte;
                                res.last      = (pos_reg + ACC_W'(1) == accum_reg);
                            end
                        end
                        pos_next = pos_reg + ACC_W'(1);
                        if (pos_next >= accum_reg)
                        begin
                            phase_next = PH_HEADER;
                            if (!res.valid)
                                res = end_report(ptype, accum_reg, ack_next, topic_next,
                                                 mstart_next);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            accum_reg  <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            topic_reg  <= '0;
            mstart_reg <= '0;
            ack_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            accum_reg  <= accum_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            topic_reg  <= topic_next;
            mstart_reg <= mstart_next;
            ack_reg    <= ack_next;
        end
    end

endmodule

[rtl/core/mrd_out_reg.sv]
// Result register of the MQTT receive deframer, driving the result channel.
// Depends on mrd_pkg and mrd_out_if.
`timescale 1ns / 1ps

module mrd_out_reg
    import mrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  res_t             res,
    output logic             free,
    mrd_out_if.source        res_ch
);

    logic       valid_reg, valid_next;
    logic [2:0] event_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // a new word may enter when no result is held or the held result leaves in the same cycle
    assign free = !valid_reg || res_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
            valid_next = 1'b1;
        else if (res_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            event_reg <= res.event_res;
            data_reg  <= res.data;
            last_reg  <= res.last;
        end
    end

    assign res_ch.valid     = valid_reg;
    assign res_ch.event_res = event_reg;
    assign res_ch.data      = data_reg;
    assign res_ch.last      = last_reg;

endmodule

[rtl/core/mqtt_receive_deframer.sv]
// Top level of the MQTT receive deframer: parser plus result register.
// Depends on mrd_pkg, mrd_in_if, mrd_out_if, mrd_parser and mrd_out_reg.
//
//   channel  dir  payload                  notes
//   rx_ch    in   opcode, rx_byte          one word per cycle
//   res_ch   out  event_res, data, last    zero or one result per input word
//
// Each accepted word is parsed in the cycle it is accepted; its result, if
// any, shows on res_ch in the next cycle from the result register.
// Sustained rate is one word per clock; rx_ch.ready drops only while a held
// result is stalled by res_ch.ready low.
// Reset returns the parser to expecting a header byte and empties the result
// register. Opcode clear does the same for the parser without a result.
`timescale 1ns / 1ps

module mqtt_receive_deframer
    import mrd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    mrd_in_if.sink     rx_ch,
    mrd_out_if.source  res_ch
);

    logic free;
    logic step;
    res_t res;

    assign rx_ch.ready = free;
    assign step        = rx_ch.valid && free;

    mrd_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .opcode  (rx_ch.opcode),
        .rx_byte (rx_ch.rx_byte),
        .res     (res)
    );

    mrd_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (res),
        .free   (free),
        .res_ch (res_ch)
    );

    a_result_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_ch.valid) |-> $past(rx_ch.valid && rx_ch.ready))
        else $error("result appeared without an accepted word");

    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_ch.valid && rx_ch.ready && rx_ch.opcode == OP_CLEAR) |=> !res_ch.valid)
        else $error("clear request produced a result");

    a_held_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && !res_ch.ready) |-> !rx_ch.ready)
        else $error("input taken while a stalled result is held");

    a_data_only_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.event_res != EV_MSG_BYTE)
            |-> (res_ch.data == 8'h00 && !res_ch.last))
        else $error("data or last set on a non-message event");

endmodule
